[rtl/gclp_pkg.sv]
// shared types, widths and constants of the greedy contiguous load partitioner
// no dependencies
`default_nettype none

package gclp_pkg;

	localparam int TaskW   = 7;
	localparam int ElemW   = 40;
	localparam int GroupW  = 31;
	localparam int LenW    = 32;
	localparam int CfgIdxW = 2;
	localparam int MaxTasksDef = 64;

	localparam logic [ElemW-1:0]  ElemMax  = {ElemW{1'b1}};
	localparam logic [GroupW-1:0] GroupMax = {GroupW{1'b1}};

	typedef enum logic [CfgIdxW-1:0] {
		REG_NUM_TASKS      = 2'd0,
		REG_TOTAL_ELEMENTS = 2'd1,
		REG_BASE_OFFSET    = 2'd2,
		REG_FIRST_GROUP    = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_RESTART,
		ST_DIV,
		ST_IDLE,
		ST_CHECK,
		ST_TAIL,
		ST_DRAIN
	} gclp_state_t;

	// saturating add of two element counts
	function automatic logic [ElemW-1:0] sat_add_elem(input logic [ElemW-1:0] a,
			input logic [ElemW-1:0] b);
		logic [ElemW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ElemW] ? ElemMax : s[ElemW-1:0];
	endfunction

	// saturating add of two group indexes
	function automatic logic [GroupW-1:0] sat_add_group(input logic [GroupW-1:0] a,
			input logic [GroupW-1:0] b);
		logic [GroupW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[GroupW] ? GroupMax : s[GroupW-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/gclp_div.sv]
// serial restoring divider: 40-bit dividend by 7-bit divisor, one quotient bit a cycle
// depends on gclp_pkg
`default_nettype none

module gclp_div
	import gclp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [ElemW-1:0] dividend,
	input  wire logic [TaskW-1:0] divisor,
	output logic                  done,
	output logic [ElemW-1:0]      quotient
);

	localparam int CntW = $clog2(ElemW);
	localparam logic [CntW-1:0] CntLast = CntW'(ElemW - 1);

	logic             busy_q;
	logic             done_q;
	logic [CntW-1:0]  cnt_q;
	logic [ElemW-1:0] dvd_q;
	logic [TaskW-1:0] rem_q;
	logic [TaskW-1:0] dsr_q;

	logic [TaskW:0] trial;
	logic [TaskW:0] diff;
	logic           qbit;

	assign trial = {rem_q, dvd_q[ElemW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign qbit  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CntLast) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient bits shift in where dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ElemW-2:0], qbit};
			rem_q <= qbit ? diff[TaskW-1:0] : trial[TaskW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

[rtl/greedy_contiguous_load_partitioner_top.sv]
// top level of the greedy contiguous load partitioner: sequencer, state and output register
// depends on gclp_pkg and gclp_div
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall     group_length, last_group
//   out      source     out_valid / out_stall   task_slot, boundary_offset, boundary_group,
//                                               last_result
//   cfg      sink       cfg_we                  cfg_index, cfg_data
//
// an item that closes a run, other than the last group, waits for the serial divide
// of the remaining elements by the remaining tasks
// the last group then emits one boundary item a cycle unless stalled, then a restart divide
// after reset and after every register write the block runs the restart divide before
// taking items; out_stall holds the output register and sequencer, not the divide
`default_nettype none

module greedy_contiguous_load_partitioner_top
	import gclp_pkg::*;
#(
	parameter int MAX_TASKS = MaxTasksDef
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [ElemW-1:0]   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [LenW-1:0]    group_length,
	input  wire logic               last_group,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [TaskW-1:0]        task_slot,
	output logic [ElemW-1:0]        boundary_offset,
	output logic [GroupW-1:0]       boundary_group,
	output logic                    last_result
);

	localparam logic [TaskW-1:0] MaxT = TaskW'(MAX_TASKS);

	gclp_state_t state_q, state_d;

	logic [TaskW-1:0]  num_tasks_q;
	logic [ElemW-1:0]  total_q;
	logic [ElemW-1:0]  base_q;
	logic [GroupW-1:0] first_group_q;

	logic [ElemW-1:0]  running_offset_q;
	logic [GroupW-1:0] groups_seen_q;
	logic [ElemW-1:0]  run_count_q;
	logic [TaskW-1:0]  current_task_q;
	logic [ElemW-1:0]  run_target_q;
	logic [ElemW-1:0]  end_q;
	logic              last_q;
	logic [TaskW-1:0]  slot_q;

	logic              out_valid_q;
	logic [TaskW-1:0]  slot_out_q;
	logic [ElemW-1:0]  offset_out_q;
	logic [GroupW-1:0] group_out_q;
	logic              last_out_q;

	logic [TaskW-1:0]  eff_t;
	logic [TaskW-1:0]  next_task;
	logic              hit;
	logic              out_free;
	logic              in_accept;
	logic [ElemW-1:0]  remaining;
	logic [GroupW-1:0] cur_group;

	logic              div_start;
	logic              div_done;
	logic [ElemW-1:0]  div_dividend;
	logic [TaskW-1:0]  div_divisor;
	logic [ElemW-1:0]  div_quotient;

	always_comb begin
		if (num_tasks_q == '0)
			eff_t = TaskW'(1);
		else if (num_tasks_q > MaxT)
			eff_t = MaxT;
		else
			eff_t = num_tasks_q;
	end

	assign next_task = current_task_q + 1'b1;
	assign hit       = (run_count_q >= run_target_q) && (next_task < eff_t);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_accept = in_valid && !in_stall;
	assign remaining = (end_q > running_offset_q) ? (end_q - running_offset_q) : '0;
	assign cur_group = sat_add_group(first_group_q, groups_seen_q);

	// next state
	always_comb begin
		state_d = state_q;
		if (cfg_we) begin
			state_d = ST_RESTART;
		end else begin
			unique case (state_q)
				ST_RESTART: state_d = ST_DIV;
				ST_DIV: begin
					if (div_done)
						state_d = ST_IDLE;
				end
				ST_IDLE: begin
					if (in_accept)
						state_d = ST_CHECK;
				end
				ST_CHECK: begin
					if (out_free) begin
						if (last_q)
							state_d = ST_TAIL;
						else if (hit)
							state_d = ST_DIV;
						else
							state_d = ST_IDLE;
					end
				end
				ST_TAIL: begin
					if (out_free && (slot_q == eff_t))
						state_d = ST_DRAIN;
				end
				ST_DRAIN: begin
					if (out_free)
						state_d = ST_RESTART;
				end
				default: state_d = ST_RESTART;
			endcase
		end
	end

	// control outputs
	always_comb begin
		in_stall     = 1'b1;
		div_start    = 1'b0;
		div_dividend = total_q;
		div_divisor  = eff_t;
		unique case (state_q) inside
			ST_RESTART: div_start = 1'b1;
			ST_IDLE:    in_stall = cfg_we;
			ST_CHECK: begin
				div_start    = out_free && hit && !last_q;
				div_dividend = remaining;
				div_divisor  = eff_t - next_task;
			end
			ST_DIV, ST_TAIL, ST_DRAIN: begin
				in_stall = 1'b1;
			end
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_RESTART;
		else
			state_q <= state_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_tasks_q   <= TaskW'(1);
			total_q       <= '0;
			base_q        <= '0;
			first_group_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_NUM_TASKS:      num_tasks_q   <= cfg_data[TaskW-1:0];
				REG_TOTAL_ELEMENTS: total_q       <= cfg_data;
				REG_BASE_OFFSET:    base_q        <= cfg_data;
				REG_FIRST_GROUP:    first_group_q <= cfg_data[GroupW-1:0];
				default:            num_tasks_q   <= num_tasks_q;
			endcase
		end
	end

	// running state of the list
	always_ff @(posedge clk) begin
		case (state_q)
			ST_RESTART: begin
				running_offset_q <= base_q;
				groups_seen_q    <= '0;
				run_count_q      <= '0;
				current_task_q   <= '0;
				end_q            <= sat_add_elem(base_q, total_q);
			end
			ST_DIV: begin
				if (div_done)
					run_target_q <= div_quotient;
			end
			ST_IDLE: begin
				if (in_accept) begin
					run_count_q      <= sat_add_elem(run_count_q, ElemW'(group_length));
					running_offset_q <= sat_add_elem(running_offset_q, ElemW'(group_length));
					if (groups_seen_q != GroupMax)
						groups_seen_q <= groups_seen_q + 1'b1;
					last_q <= last_group;
				end
			end
			ST_CHECK: begin
				if (out_free) begin
					if (hit) begin
						current_task_q <= next_task;
						run_count_q    <= '0;
						slot_q         <= next_task + 1'b1;
					end else begin
						slot_q <= next_task;
					end
				end
			end
			ST_TAIL: begin
				if (out_free && (slot_q != eff_t))
					slot_q <= slot_q + 1'b1;
			end
			default: begin
				last_q <= last_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!cfg_we && out_free && (((state_q == ST_CHECK) && hit) || (state_q == ST_TAIL)))
			out_valid_q <= 1'b1;
		else if (out_free)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if ((state_q == ST_CHECK) && hit) begin
				slot_out_q   <= next_task;
				offset_out_q <= running_offset_q;
				group_out_q  <= cur_group;
				last_out_q   <= 1'b0;
			end else if (state_q == ST_TAIL) begin
				slot_out_q   <= slot_q;
				offset_out_q <= running_offset_q;
				group_out_q  <= cur_group;
				last_out_q   <= (slot_q == eff_t);
			end
		end
	end

	gclp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign out_valid       = out_valid_q;
	assign task_slot       = slot_out_q;
	assign boundary_offset = offset_out_q;
	assign boundary_group  = group_out_q;
	assign last_result     = last_out_q;

endmodule

`default_nettype wire

[test/tb.sv]
// self-checking testbench for greedy_contiguous_load_partitioner_top: directed and random group lists
// predicts every boundary item in the testbench itself; depends on gclp_pkg and the rtl
module tb;
	import gclp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [LenW-1:0] len;
		logic            last;
		bit              wait_drain;
	} group_item_t;

	typedef struct {
		logic [TaskW-1:0]  slot;
		logic [ElemW-1:0]  offset;
		logic [GroupW-1:0] group;
		logic              last;
	} boundary_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [ElemW-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [LenW-1:0]    group_length = '0;
	logic               last_group = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [TaskW-1:0]   task_slot;
	logic [ElemW-1:0]   boundary_offset;
	logic [GroupW-1:0]  boundary_group;
	logic               last_result;

	greedy_contiguous_load_partitioner_top i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.group_length    (group_length),
		.last_group      (last_group),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.task_slot       (task_slot),
		.boundary_offset (boundary_offset),
		.boundary_group  (boundary_group),
		.last_result     (last_result)
	);

	always #5 clk = ~clk;

	group_item_t group_q[$];
	boundary_t   boundary_q[$];
	int          mismatch_count = 0;

	// register copies and partition state of the predictor
	logic [TaskW-1:0]  reg_tasks = 7'd1;
	logic [ElemW-1:0]  reg_total = '0;
	logic [ElemW-1:0]  reg_base = '0;
	logic [GroupW-1:0] reg_first = '0;
	logic [ElemW-1:0]  acc_offset;
	logic [ElemW-1:0]  run_elems;
	logic [ElemW-1:0]  run_goal;
	logic [GroupW-1:0] groups_done;
	int                open_task;

	function automatic int active_tasks();
		if (reg_tasks == 0)
			return 1;
		if (reg_tasks > MaxTasksDef)
			return MaxTasksDef;
		return int'(reg_tasks);
	endfunction

	function automatic logic [ElemW-1:0] add_elems(input logic [ElemW-1:0] a,
			input logic [ElemW-1:0] b);
		logic [ElemW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ElemW] ? ElemMax : s[ElemW-1:0];
	endfunction

	function automatic logic [GroupW-1:0] group_index();
		logic [GroupW:0] g;
		g = {1'b0, reg_first} + {1'b0, groups_done};
		return g[GroupW] ? GroupMax : g[GroupW-1:0];
	endfunction

	task automatic restart_list();
		acc_offset  = reg_base;
		groups_done = '0;
		run_elems   = '0;
		open_task   = 0;
		run_goal    = reg_total / ElemW'(active_tasks());
	endtask

	task automatic record_boundary(input int slot, input logic last);
		boundary_t entry;
		entry = '{slot: TaskW'(slot), offset: acc_offset, group: group_index(), last: last};
		boundary_q.insert(boundary_q.size(), entry);
	endtask

	task automatic predict_group(input logic [LenW-1:0] len, input logic last);
		int               t;
		logic [ElemW-1:0] end_off;
		logic [ElemW-1:0] left;
		t = active_tasks();
		run_elems  = add_elems(run_elems, ElemW'(len));
		acc_offset = add_elems(acc_offset, ElemW'(len));
		if (groups_done != GroupMax)
			groups_done++;
		if (run_elems >= run_goal && open_task + 1 < t) begin
			end_off = add_elems(reg_base, reg_total);
			left = (end_off > acc_offset) ? end_off - acc_offset : '0;
			open_task++;
			record_boundary(open_task, 1'b0);
			run_elems = '0;
			run_goal  = left / ElemW'(t - open_task);
		end
		// close the list: every slot not yet filled gets the offset reached after the last group
		if (last) begin
			for (int s = open_task + 1; s <= t; s++)
				record_boundary(s, s == t);
			restart_list();
		end
	endtask

	// driver: bursts of items with random gaps
	int burst_left = 1;
	int gap_left = 0;
	bit send_now;

	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict_group(group_length, last_group);
			void'(group_q.pop_front());
		end
		send_now = in_valid && in_stall;
		if (!send_now && arst_n && group_q.size() != 0) begin
			if (gap_left != 0) begin
				gap_left--;
			end else if (!group_q[0].wait_drain || boundary_q.size() == 0) begin
				send_now = 1'b1;
				group_length <= group_q[0].len;
				last_group   <= group_q[0].last;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
				end
			end
		end
		in_valid <= send_now;
	end

	// monitor and receiver stall pattern
	boundary_t want;
	int        stall_mode = 0;
	int        mode_left = 100;
	int        cycle_count = 0;
	bit        stall_next;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (boundary_q.size() == 0) begin
				$display("%0t: boundary item expected none actual slot %0d offset %0h group %0h last %0b",
					$time, task_slot, boundary_offset, boundary_group, last_result);
				mismatch_count++;
			end else begin
				want = boundary_q.pop_front();
				if (task_slot !== want.slot) begin
					$display("%0t: task_slot expected %0d actual %0d", $time, want.slot, task_slot);
					mismatch_count++;
				end
				if (boundary_offset !== want.offset) begin
					$display("%0t: boundary_offset expected %0h actual %0h", $time, want.offset,
						boundary_offset);
					mismatch_count++;
				end
				if (boundary_group !== want.group) begin
					$display("%0t: boundary_group expected %0h actual %0h", $time, want.group,
						boundary_group);
					mismatch_count++;
				end
				if (last_result !== want.last) begin
					$display("%0t: last_result expected %0b actual %0b", $time, want.last,
						last_result);
					mismatch_count++;
				end
			end
		end
		cycle_count++;
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(50, 300);
		end else begin
			mode_left--;
		end
		case (stall_mode)
			0: stall_next = 1'b0;
			1: stall_next = ($urandom_range(0, 3) == 0);
			2: stall_next = ($urandom_range(0, 3) != 0);
			default: stall_next = (cycle_count % 5) < 3;
		endcase
		out_stall <= stall_next;
	end

	task automatic push_group(input logic [LenW-1:0] len, input logic last,
			input bit wait_drain = 1'b0);
		group_item_t entry;
		entry = '{len: len, last: last, wait_drain: wait_drain};
		group_q.insert(group_q.size(), entry);
	endtask

	// all items accepted, all boundaries seen, then room for a trailing divide
	task automatic wait_idle();
		@(negedge clk);
		while (group_q.size() != 0 || in_valid || boundary_q.size() != 0)
			@(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [ElemW-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_NUM_TASKS:      reg_tasks = value[TaskW-1:0];
			REG_TOTAL_ELEMENTS: reg_total = value;
			REG_BASE_OFFSET:    reg_base = value;
			REG_FIRST_GROUP:    reg_first = value[GroupW-1:0];
			default: ;
		endcase
		restart_list();
		// let the restart divide finish
		repeat (50) @(posedge clk);
	endtask

	task automatic set_config(input int tasks, input logic [ElemW-1:0] total,
			input logic [ElemW-1:0] base, input logic [GroupW-1:0] first);
		logic [ElemW-1:0] noise;
		wait_idle();
		noise = ElemW'({$urandom(), $urandom()});
		write_reg(REG_NUM_TASKS, {noise[ElemW-1:TaskW], TaskW'(tasks)});
		write_reg(REG_TOTAL_ELEMENTS, total);
		write_reg(REG_BASE_OFFSET, base);
		noise = ElemW'({$urandom(), $urandom()});
		write_reg(REG_FIRST_GROUP, {noise[ElemW-1:GroupW], first});
	endtask

	task automatic random_phase(inout int sent);
		logic [LenW-1:0]   lens[$];
		logic [LenW-1:0]   len_new;
		logic [ElemW-1:0]  sum;
		logic [ElemW-1:0]  total;
		logic [ElemW-1:0]  base;
		logic [GroupW-1:0] first;
		int                tasks;
		int                n;
		int                pick;
		int                mode;
		int                lists;
		pick = $urandom_range(0, 19);
		case (pick) inside
			0:       tasks = 0;
			1:       tasks = $urandom_range(MaxTasksDef + 1, 127);
			2, 3:    tasks = MaxTasksDef;
			4, 5:    tasks = 1;
			6, 7, 8: tasks = $urandom_range(7, 20);
			default: tasks = $urandom_range(2, 6);
		endcase
		n = $urandom_range(1, 12);
		mode = $urandom_range(0, 3);
		sum = '0;
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: len_new = LenW'($urandom_range(0, 40));
				1: len_new = $urandom();
				2: begin
					case ($urandom_range(0, 2))
						0:       len_new = '0;
						1:       len_new = '1;
						default: len_new = LenW'($urandom_range(0, 100));
					endcase
				end
				default: len_new = LenW'($urandom_range(0, 2000));
			endcase
			lens.insert(lens.size(), len_new);
			sum += ElemW'(lens[i]);
		end
		// mostly the true total; sometimes fewer elements announced than sent, sometimes a random total
		pick = $urandom_range(0, 19);
		if (pick < 14)
			total = sum;
		else if (pick < 17)
			total = sum >> $urandom_range(1, 4);
		else
			total = ElemW'({$urandom(), $urandom()});
		pick = $urandom_range(0, 9);
		if (pick < 6)
			base = ElemW'($urandom_range(0, 1000000));
		else if (pick < 8)
			base = ElemW'({$urandom(), $urandom()});
		else
			base = ElemMax - ElemW'($urandom_range(0, 5000));
		pick = $urandom_range(0, 9);
		if (pick < 6)
			first = GroupW'($urandom_range(0, 1000));
		else if (pick < 8)
			first = GroupW'($urandom());
		else
			first = GroupMax - GroupW'($urandom_range(0, 8));
		set_config(tasks, total, base, first);
		lists = ($urandom_range(0, 4) == 0) ? 2 : 1;
		for (int l = 0; l < lists; l++) begin
			for (int i = 0; i < n; i++) begin
				// an unterminated list is cut short by the next register write
				push_group(lens[i], i == n - 1 && (l < lists - 1 || $urandom_range(0, 9) != 0),
					$urandom_range(0, 19) == 0);
			end
		end
		sent += n * lists;
	endtask

	int sent = 0;

	initial begin
		restart_list();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// reset settings: a single task over an empty list
		push_group('0, 1'b1);

		// four even runs
		set_config(4, 40'd100, 40'h1000, 31'd5);
		push_group(32'd25, 1'b0);
		push_group(32'd25, 1'b0);
		push_group(32'd25, 1'b0);
		push_group(32'd25, 1'b1);

		// zero tasks acts as one: no boundary before the end
		set_config(0, 40'h2_FFFF_FFFD, '0, '0);
		push_group('1, 1'b0);
		push_group('1, 1'b0);
		push_group('1, 1'b1);

		// task count above the maximum, offset and group index saturate
		set_config(127, 40'd1000, 40'hFF_FFFF_FF00, 31'h7FFF_FFFE);
		push_group(32'd300, 1'b0);
		push_group(32'd300, 1'b0, 1'b1);
		push_group(32'd400, 1'b1);

		// more elements than announced
		set_config(3, 40'd10, '0, '0);
		push_group(32'd1000, 1'b0);
		push_group(32'd1000, 1'b0);
		push_group(32'd1000, 1'b1);

		// register write in the middle of a list restarts it
		set_config(5, 40'd500, 40'd7, 31'd9);
		push_group(32'd100, 1'b0);
		push_group(32'd100, 1'b0);
		set_config(2, ElemMax, '0, GroupMax);
		push_group('1, 1'b0);
		push_group('0, 1'b1);

		while (sent < 280)
			random_phase(sent);

		wait_idle();
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
